// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial drive command parser package
// Shared widths, register indexes, result codes, characters and the
// control/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int BUFFER_DEPTH_DEF = 8;

	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 16;
	localparam int CMD_W   = 4;
	localparam int LEVEL_W = 7;
	localparam int POS_W   = 16;
	localparam int ACC_W   = 24;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_FWD_SPEED  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_BWD_SPEED  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_TURN_SPEED = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_TURN_LEVEL = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_LIMIT      = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_SERVO_MIN  = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_SERVO_MAX  = 3'd6;

	// register reset values
	localparam logic [LEVEL_W-1:0] RST_FWD_SPEED  = 7'd50;
	localparam logic [LEVEL_W-1:0] RST_BWD_SPEED  = 7'd40;
	localparam logic [LEVEL_W-1:0] RST_TURN_SPEED = 7'd40;
	localparam logic [LEVEL_W-1:0] RST_TURN_LEVEL = 7'd70;
	localparam logic [LEVEL_W-1:0] RST_LIMIT      = 7'd100;
	localparam logic [POS_W-1:0]   RST_SERVO_MIN  = 16'd1000;
	localparam logic [POS_W-1:0]   RST_SERVO_MAX  = 16'd2000;

	// result codes
	localparam logic [CMD_W-1:0] CMD_FORWARD   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_BACKWARD  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd2;
	localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd3;
	localparam logic [CMD_W-1:0] CMD_STOP      = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SERVO     = 4'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_ANGLE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_TOO_LONG  = 4'd8;

	// characters
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CASE_BIT  = 8'h20;
	localparam logic [7:0] LOWER_W   = 8'h77;
	localparam logic [7:0] LOWER_S   = 8'h73;
	localparam logic [7:0] LOWER_A   = 8'h61;
	localparam logic [7:0] LOWER_D   = 8'h64;
	localparam logic [7:0] LOWER_X   = 8'h78;
	localparam logic [7:0] LOWER_T   = 8'h74;

	localparam logic [ACC_W-1:0] ACC_MAX    = 24'hFF_FFFF;
	localparam logic [3:0]       DIGIT_BASE = 4'd10;

	typedef struct packed {
		logic store;
		logic clear_fill;
		logic walk_start;
		logic walk_read;
		logic load_line;
		logic load_long;
	} scp_cmd_t;

	typedef struct packed {
		logic rx_term;
		logic fill_zero;
		logic fill_full;
		logic walk_last;
		logic out_free;
	} scp_stat_t;

endpackage

// ===== rtl/scp_if.sv =====
// ----------------------------------------------------------------------------
// Serial drive command parser channels
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface scp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scp_res_if;
	import scp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [7:0]         speed;
	logic [LEVEL_W-1:0]        steer_level;
	logic [POS_W-1:0]          servo_position;
	logic [7:0]                bad_letter;

	modport source (output valid, output command, output speed, output steer_level,
		output servo_position, output bad_letter, input ready);
	modport sink (input valid, input command, input speed, input steer_level,
		input servo_position, input bad_letter, output ready);
endinterface

interface scp_cfg_if;
	import scp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/scp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Serial drive command parser controller
// Sequences byte storage, the line walk and loading of results.
// ----------------------------------------------------------------------------
module scp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  scp_pkg::scp_stat_t stat,
	output scp_pkg::scp_cmd_t  cmd
);
	import scp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_LINE  = 3'd3;
	localparam logic [2:0] ST_LONG  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign rx_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (rx_valid) begin
					if (stat.rx_term) begin
						if (!stat.fill_zero) begin
							cmd.walk_start = 1'b1;
							state_d        = ST_WALK;
						end
					end else if (!stat.fill_full) begin
						cmd.store = 1'b1;
					end else begin
						cmd.clear_fill = 1'b1;
						state_d        = ST_LONG;
					end
				end
			end
			ST_WALK: begin
				cmd.walk_read = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_LINE;
			end
			ST_LINE: begin
				if (stat.out_free) begin
					cmd.load_line = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_LONG: begin
				if (stat.out_free) begin
					cmd.load_long = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/scp_dp.sv =====
// ----------------------------------------------------------------------------
// Serial drive command parser datapath
// Line buffer, value accumulator, configuration registers, decode and the
// result register.
// ----------------------------------------------------------------------------
module scp_dp #(
	parameter int BufferDepth = scp_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   rx_byte,
	input  logic                         cfg_valid,
	input  logic [scp_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [scp_pkg::CFG_DW-1:0]   cfg_data,
	input  scp_pkg::scp_cmd_t            cmd,
	output scp_pkg::scp_stat_t           stat,
	input  logic                         res_ready,
	output logic                         res_valid,
	output logic [scp_pkg::CMD_W-1:0]    command,
	output logic signed [7:0]            speed,
	output logic [scp_pkg::LEVEL_W-1:0]  steer_level,
	output logic [scp_pkg::POS_W-1:0]    servo_position,
	output logic [7:0]                   bad_letter
);
	import scp_pkg::*;

	localparam int AW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
	localparam int FW = $clog2(BufferDepth + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(BufferDepth);

	// configuration registers
	logic [LEVEL_W-1:0] fwd_speed_q, bwd_speed_q, turn_speed_q, turn_level_q, limit_q;
	logic [POS_W-1:0]   servo_min_q, servo_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_speed_q  <= RST_FWD_SPEED;
			bwd_speed_q  <= RST_BWD_SPEED;
			turn_speed_q <= RST_TURN_SPEED;
			turn_level_q <= RST_TURN_LEVEL;
			limit_q      <= RST_LIMIT;
			servo_min_q  <= RST_SERVO_MIN;
			servo_max_q  <= RST_SERVO_MAX;
		end else if (cfg_valid) begin
			case (cfg_addr)
				CFG_FWD_SPEED:  fwd_speed_q  <= cfg_data[LEVEL_W-1:0];
				CFG_BWD_SPEED:  bwd_speed_q  <= cfg_data[LEVEL_W-1:0];
				CFG_TURN_SPEED: turn_speed_q <= cfg_data[LEVEL_W-1:0];
				CFG_TURN_LEVEL: turn_level_q <= cfg_data[LEVEL_W-1:0];
				CFG_LIMIT:      limit_q      <= cfg_data[LEVEL_W-1:0];
				CFG_SERVO_MIN:  servo_min_q  <= cfg_data[POS_W-1:0];
				CFG_SERVO_MAX:  servo_max_q  <= cfg_data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// line buffer and fill count
	logic [7:0]    mem [BufferDepth];
	logic [FW-1:0] fill_q;
	logic [AW-1:0] rd_idx_q;
	logic [7:0]    rd_data_s1;
	logic          rd_vld_s1;
	logic          rd_first_s1;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[fill_q[AW-1:0]] <= rx_byte;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			if (cmd.clear_fill || cmd.load_line) begin
				fill_q <= '0;
			end else if (cmd.store) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.walk_start) begin
				rd_idx_q <= '0;
			end else if (cmd.walk_read) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
			rd_vld_s1   <= cmd.walk_read;
			rd_first_s1 <= cmd.walk_read && (rd_idx_q == '0);
		end
	end

	// digit accumulation, saturating
	logic [7:0]       letter_q;
	logic [ACC_W-1:0] acc_q;
	logic             is_digit;
	logic [3:0]       digit;
	logic [ACC_W+3:0] acc_mul;
	logic [ACC_W-1:0] acc_next;

	assign is_digit = (rd_data_s1 >= CHAR_ZERO) && (rd_data_s1 <= CHAR_NINE);
	assign digit    = 4'(rd_data_s1 - CHAR_ZERO);
	assign acc_mul  = (ACC_W+4)'(acc_q) * (ACC_W+4)'(DIGIT_BASE) + (ACC_W+4)'(digit);
	assign acc_next = (acc_mul > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : acc_mul[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			acc_q <= '0;
		end else if (rd_vld_s1) begin
			if (rd_first_s1) begin
				letter_q <= rd_data_s1;
			end else if (is_digit) begin
				acc_q <= acc_next;
			end
		end
	end

	// decode
	function automatic logic [LEVEL_W-1:0] pick_value(
		input logic [ACC_W-1:0]   v,
		input logic [LEVEL_W-1:0] dflt,
		input logic [LEVEL_W-1:0] lim
	);
		logic [ACC_W-1:0] t;
		t = (v == '0) ? ACC_W'(dflt) : v;
		return (t > ACC_W'(lim)) ? lim : t[LEVEL_W-1:0];
	endfunction

	logic [LEVEL_W-1:0] fwd_val, bwd_val, turn_val;
	logic [7:0]         letter_lc;
	logic               servo_ok;
	logic [CMD_W-1:0]   cmd_d;
	logic [7:0]         speed_d;
	logic [LEVEL_W-1:0] level_d;
	logic [POS_W-1:0]   pos_d;
	logic [7:0]         bad_d;

	assign fwd_val   = pick_value(acc_q, fwd_speed_q, limit_q);
	assign bwd_val   = pick_value(acc_q, bwd_speed_q, limit_q);
	assign turn_val  = pick_value(acc_q, turn_level_q, limit_q);
	assign letter_lc = letter_q | CASE_BIT;
	assign servo_ok  = (acc_q >= ACC_W'(servo_min_q)) && (acc_q <= ACC_W'(servo_max_q));

	always_comb begin
		cmd_d   = CMD_UNKNOWN;
		speed_d = '0;
		level_d = '0;
		pos_d   = '0;
		bad_d   = '0;
		case (letter_lc)
			LOWER_W: begin
				cmd_d   = CMD_FORWARD;
				speed_d = {1'b0, fwd_val};
			end
			LOWER_S: begin
				cmd_d   = CMD_BACKWARD;
				speed_d = 8'(8'd0 - {1'b0, bwd_val});
			end
			LOWER_A: begin
				cmd_d   = CMD_LEFT;
				speed_d = {1'b0, turn_speed_q};
				level_d = turn_val;
			end
			LOWER_D: begin
				cmd_d   = CMD_RIGHT;
				speed_d = {1'b0, turn_speed_q};
				level_d = turn_val;
			end
			LOWER_X: begin
				cmd_d = CMD_STOP;
			end
			LOWER_T: begin
				if (servo_ok) begin
					cmd_d = CMD_SERVO;
					pos_d = acc_q[POS_W-1:0];
				end else begin
					cmd_d = CMD_BAD_ANGLE;
				end
			end
			default: begin
				cmd_d = CMD_UNKNOWN;
				bad_d = letter_q;
			end
		endcase
	end

	// result register
	logic               out_valid_q;
	logic [CMD_W-1:0]   command_q;
	logic [7:0]         speed_q;
	logic [LEVEL_W-1:0] level_q;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_line || cmd.load_long) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_line) begin
			command_q <= cmd_d;
			speed_q   <= speed_d;
			level_q   <= level_d;
			pos_q     <= pos_d;
			bad_q     <= bad_d;
		end else if (cmd.load_long) begin
			command_q <= CMD_TOO_LONG;
			speed_q   <= '0;
			level_q   <= '0;
			pos_q     <= '0;
			bad_q     <= '0;
		end
	end

	assign res_valid      = out_valid_q;
	assign command        = command_q;
	assign speed          = $signed(speed_q);
	assign steer_level    = level_q;
	assign servo_position = pos_q;
	assign bad_letter     = bad_q;

	assign stat.rx_term   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
	assign stat.fill_zero = (fill_q == '0);
	assign stat.fill_full = (fill_q >= FILL_MAX);
	assign stat.walk_last = (FW'(rd_idx_q) == (fill_q - FW'(1)));
	assign stat.out_free  = !out_valid_q || res_ready;

endmodule

// ===== rtl/serial_drive_command_parser.sv =====
// ----------------------------------------------------------------------------
// Serial drive command parser
// Collects the characters of a text drive command and reports one decoded
// command for every terminated non-empty line, or a too-long result on overflow.
// ----------------------------------------------------------------------------
// Usage:
//   rx  - one character per item. Ordinary characters are stored while the
//         block stays ready for the next one.
//   res - zero or one result item per character. A CR or LF ending a line of
//         n buffered characters walks the line buffer through its single read
//         port, one character a cycle, then loads the result once the output
//         register is free; rx.ready stays low until then. A character that
//         finds the buffer full yields a too-long result once the register is free.
//   cfg - register writes, taken in any cycle; write only while idle.
// A finished result sits in an output register: while the receiver stalls,
// further characters are still stored, and only the next result waits.
// Reset clears the fill count, drops any pending result and restores the
// register defaults; the line buffer itself is not cleared.
// ----------------------------------------------------------------------------
module serial_drive_command_parser #(
	parameter int BUFFER_DEPTH = scp_pkg::BUFFER_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	scp_byte_if.sink  rx,
	scp_res_if.source res,
	scp_cfg_if.sink   cfg
);
	import scp_pkg::*;

	scp_cmd_t  cmd;
	scp_stat_t stat;
	logic      rx_ready;

	// configuration writes never stall
	assign cfg.ready = 1'b1;
	assign rx.ready  = rx_ready;

	// controller: decides what each accepted item does and paces the walk
	scp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: buffer, accumulator, registers, decode and result register
	scp_dp #(
		.BufferDepth (BUFFER_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx.rx_byte),
		.cfg_valid      (cfg.valid),
		.cfg_addr       (cfg.addr),
		.cfg_data       (cfg.data),
		.cmd            (cmd),
		.stat           (stat),
		.res_ready      (res.ready),
		.res_valid      (res.valid),
		.command        (res.command),
		.speed          (res.speed),
		.steer_level    (res.steer_level),
		.servo_position (res.servo_position),
		.bad_letter     (res.bad_letter)
	);

`ifndef SYNTHESIS
	// a terminator on a non-empty line must hold off input for the walk
	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && stat.rx_term && !stat.fill_zero) |=> !rx.ready)
		else $error("input accepted during line walk");

	// an overflowing character empties the buffer
	a_overflow_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && !stat.rx_term && stat.fill_full) |=> stat.fill_zero)
		else $error("buffer not emptied after overflow");

	// a stored character leaves the buffer non-empty
	a_store_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && !stat.rx_term && !stat.fill_full) |=> !stat.fill_zero)
		else $error("stored character lost");

	// a result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !(cmd.load_line || cmd.load_long))
		else $error("pending result overwritten");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial drive command parser testbench
// Sends command lines a character at a time, keeps its own model of the
// line buffer and registers, and checks every result item field by field.
// The directed tests come first. Back-pressure and random traffic follow,
// under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import scp_pkg::*;

	localparam int    LINE_DEPTH    = BUFFER_DEPTH_DEF;
	localparam int    SETTLE_CYCLES = 16;    // margin after the longest line walk
	localparam int    LONG_HOLD     = 300;   // receiver hold-off under pressure
	localparam int    PHASE_BYTES   = 160;   // random characters per traffic phase
	localparam string DRIVE_LETTERS = "WSADXTwsadxt";

	// one decoded command as it leaves the block
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic signed [7:0]  speed;
		logic [LEVEL_W-1:0] steer_level;
		logic [POS_W-1:0]   servo_position;
		logic [7:0]         bad_letter;
	} drive_cmd_t;

	logic clk;
	logic arst_n;

	scp_byte_if rx_ch ();
	scp_res_if  res_ch ();
	scp_cfg_if  cfg_ch ();

	serial_drive_command_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// --------------------------------------------------------------------
	// Clock
	// --------------------------------------------------------------------
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// --------------------------------------------------------------------
	// Shadow of the block: register copies, line buffer and fill level
	// --------------------------------------------------------------------
	logic [LEVEL_W-1:0] reg_fwd_speed;
	logic [LEVEL_W-1:0] reg_bwd_speed;
	logic [LEVEL_W-1:0] reg_turn_speed;
	logic [LEVEL_W-1:0] reg_turn_level;
	logic [LEVEL_W-1:0] reg_limit;
	logic [POS_W-1:0]   reg_servo_min;
	logic [POS_W-1:0]   reg_servo_max;
	logic [7:0]         line_chars [LINE_DEPTH];
	int                 chars_held;

	// decoded commands still owed by the block, oldest first
	drive_cmd_t pending_cmds [$];

	// idling controls and run statistics
	int sender_idle_pct;
	int sink_stall_pct;
	bit hold_req  = 1'b0;
	int hold_left = 0;
	int fail_count    = 0;
	int bytes_sent    = 0;
	int results_seen  = 0;
	int settings_used = 1;
	int cmd_tally [9];

	// Substitute the default for a zero value, then clamp to the limit.
	function automatic int unsigned clamp_value(input int unsigned v,
			input int unsigned dflt);
		if (v == 0)
			v = dflt;
		if (v > reg_limit)
			v = reg_limit;
		return v;
	endfunction

	// Advance the shadow by one character; return 1 with the command it
	// yields, if any.
	function automatic bit parse_char(input logic [7:0] ch, output drive_cmd_t cmd);
		int unsigned acc;
		int unsigned digit;
		int unsigned v;
		int          i;
		logic [7:0]  letter;
		cmd = '0;
		if (ch == CHAR_CR || ch == CHAR_LF) begin
			// a terminator on an empty line is silently dropped
			if (chars_held == 0)
				return 1'b0;
			letter = line_chars[0];
			acc = 0;
			for (i = 1; i < chars_held; i++) begin
				if (line_chars[i] >= CHAR_ZERO && line_chars[i] <= CHAR_NINE) begin
					digit = line_chars[i] - CHAR_ZERO;
					if (acc > (ACC_MAX - digit) / DIGIT_BASE)
						acc = ACC_MAX;
					else
						acc = acc * DIGIT_BASE + digit;
				end
			end
			chars_held = 0;
			case (letter | CASE_BIT)
				LOWER_W: begin
					cmd.command = CMD_FORWARD;
					cmd.speed   = 8'(clamp_value(acc, reg_fwd_speed));
				end
				LOWER_S: begin
					cmd.command = CMD_BACKWARD;
					cmd.speed   = 8'(0 - clamp_value(acc, reg_bwd_speed));
				end
				LOWER_A, LOWER_D: begin
					cmd.command     = ((letter | CASE_BIT) == LOWER_A) ? CMD_LEFT : CMD_RIGHT;
					cmd.speed       = {1'b0, reg_turn_speed};
					cmd.steer_level = LEVEL_W'(clamp_value(acc, reg_turn_level));
				end
				LOWER_X: cmd.command = CMD_STOP;
				LOWER_T: begin
					if (acc >= reg_servo_min && acc <= reg_servo_max) begin
						cmd.command        = CMD_SERVO;
						cmd.servo_position = POS_W'(acc);
					end else begin
						cmd.command = CMD_BAD_ANGLE;
					end
				end
				default: begin
					cmd.command    = CMD_UNKNOWN;
					cmd.bad_letter = letter;
				end
			endcase
			return 1'b1;
		end
		if (chars_held < LINE_DEPTH) begin
			line_chars[chars_held] = ch;
			chars_held++;
			return 1'b0;
		end
		// buffer full: the character is lost and the line thrown away
		chars_held  = 0;
		cmd.command = CMD_TOO_LONG;
		return 1'b1;
	endfunction

	// --------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off counted here on request
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req      <= 1'b0;
			hold_left     <= LONG_HOLD;
			res_ch.ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			res_ch.ready  <= 1'b0;
		end else begin
			res_ch.ready  <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// --------------------------------------------------------------------
	// Result checker: compare each accepted item with the oldest prediction
	// --------------------------------------------------------------------
	always @(posedge clk) begin : check_result
		drive_cmd_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_cmds.size() == 0) begin
				$error("unexpected result item: command %0d", res_ch.command);
				fail_count++;
			end else begin
				want = pending_cmds.pop_front();
				results_seen++;
				cmd_tally[want.command]++;
				if (res_ch.command !== want.command) begin
					$error("command: expected %0d, got %0d", want.command, res_ch.command);
					fail_count++;
				end
				if (res_ch.speed !== want.speed) begin
					$error("speed: expected %0d, got %0d", want.speed, res_ch.speed);
					fail_count++;
				end
				if (res_ch.steer_level !== want.steer_level) begin
					$error("steer_level: expected %0d, got %0d", want.steer_level,
						res_ch.steer_level);
					fail_count++;
				end
				if (res_ch.servo_position !== want.servo_position) begin
					$error("servo_position: expected %0d, got %0d", want.servo_position,
						res_ch.servo_position);
					fail_count++;
				end
				if (res_ch.bad_letter !== want.bad_letter) begin
					$error("bad_letter: expected 0x%02h, got 0x%02h", want.bad_letter,
						res_ch.bad_letter);
					fail_count++;
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// Stimulus helpers
	// --------------------------------------------------------------------

	// Offer one character, idling at random first; hold valid until taken.
	// Valid stays high on return so back-to-back items follow without a gap.
	task automatic send_char(input logic [7:0] ch);
		drive_cmd_t cmd;
		while ($urandom_range(99) < sender_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= ch;
		do
			@(posedge clk);
		while (rx_ch.ready !== 1'b1);
		bytes_sent++;
		if (parse_char(ch, cmd))
			pending_cmds.push_back(cmd);
	endtask

	task automatic send_line(input string body, input logic [7:0] term);
		int i;
		for (i = 0; i < body.len(); i++)
			send_char(body[i]);
		send_char(term);
	endtask

	// Drop valid and wait until every owed result has come, then let the
	// block finish any walk that is still under way.
	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; valid is left high for a following write.
	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_FWD_SPEED:  reg_fwd_speed  = data[LEVEL_W-1:0];
			CFG_BWD_SPEED:  reg_bwd_speed  = data[LEVEL_W-1:0];
			CFG_TURN_SPEED: reg_turn_speed = data[LEVEL_W-1:0];
			CFG_TURN_LEVEL: reg_turn_level = data[LEVEL_W-1:0];
			CFG_LIMIT:      reg_limit      = data[LEVEL_W-1:0];
			CFG_SERVO_MIN:  reg_servo_min  = data[POS_W-1:0];
			CFG_SERVO_MAX:  reg_servo_max  = data[POS_W-1:0];
			default: ;
		endcase
	endtask

	// Rewrite every register, only once the block has gone quiet.
	task automatic apply_settings(input logic [CFG_DW-1:0] fwd, input logic [CFG_DW-1:0] bwd,
			input logic [CFG_DW-1:0] turn_spd, input logic [CFG_DW-1:0] turn_lvl,
			input logic [CFG_DW-1:0] limit, input logic [CFG_DW-1:0] smin,
			input logic [CFG_DW-1:0] smax);
		settle();
		write_reg(CFG_FWD_SPEED, fwd);
		write_reg(CFG_BWD_SPEED, bwd);
		write_reg(CFG_TURN_SPEED, turn_spd);
		write_reg(CFG_TURN_LEVEL, turn_lvl);
		write_reg(CFG_LIMIT, limit);
		write_reg(CFG_SERVO_MIN, smin);
		write_reg(CFG_SERVO_MAX, smax);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// any character other than a terminator or a digit
	function automatic logic [7:0] filler_char();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(255));
		while (ch == CHAR_CR || ch == CHAR_LF || (ch >= CHAR_ZERO && ch <= CHAR_NINE));
		return ch;
	endfunction

	// servo positions clustered on the edges of the accepted window
	function automatic int unsigned servo_guess();
		case ($urandom_range(5))
			0:       return reg_servo_min;
			1:       return reg_servo_max;
			2:       return (reg_servo_min == 0) ? 0 : reg_servo_min - 1;
			3:       return reg_servo_max + 1;
			4:       return (reg_servo_min <= reg_servo_max) ?
					$urandom_range(reg_servo_max, reg_servo_min) : $urandom_range(65535);
			default: return $urandom_range(9999999);
		endcase
	endfunction

	// Build and send one line: mostly well formed with random content, the
	// rest over-long lines, raw noise and bare terminators.
	task automatic send_random_line();
		logic [7:0] seq [$];
		logic [7:0] letter;
		string      digits;
		int         kind;
		int         i;
		kind   = $urandom_range(99);
		letter = DRIVE_LETTERS[$urandom_range(DRIVE_LETTERS.len() - 1)];
		if (kind < 75) begin
			if ($urandom_range(9) == 0)
				letter = 8'($urandom_range(255));
			if ((letter | CASE_BIT) == LOWER_T) begin
				digits = $sformatf("%0d", servo_guess());
			end else begin
				case ($urandom_range(9))
					0, 1, 2:    digits = "";
					3:          digits = "0";
					4, 5, 6, 7: digits = $sformatf("%0d", $urandom_range(150));
					default:    digits = $sformatf("%0d", $urandom_range(9999999));
				endcase
			end
			seq.push_back(letter);
			for (i = 0; i < digits.len(); i++)
				seq.push_back(digits[i]);
			// slip a skipped character in while the line still fits
			if (seq.size() < LINE_DEPTH && $urandom_range(3) == 0)
				seq.insert($urandom_range(seq.size(), 1), filler_char());
			seq.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
		end else if (kind < 85) begin
			seq.push_back(letter);
			repeat ($urandom_range(LINE_DEPTH + 3, LINE_DEPTH))
				seq.push_back($urandom_range(1) ? 8'(CHAR_ZERO + $urandom_range(9)) :
					filler_char());
			if ($urandom_range(1))
				seq.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
		end else if (kind < 93) begin
			repeat ($urandom_range(4, 1))
				seq.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(2, 1))
				seq.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
		end
		foreach (seq[k])
			send_char(seq[k]);
	endtask

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------

	// The letters W, S, A, D and X in mixed case, with and without a value, at the
	// reset register values; D150 must be clamped to the limit.
	task automatic test_drive_letters();
		send_line("W", CHAR_CR);
		send_line("s9", CHAR_LF);
		send_line("a", CHAR_CR);
		send_line("D150", CHAR_LF);
		send_line("x", CHAR_CR);
		settle();
	endtask

	// The servo window: upper edge accepted, one below the lower edge refused.
	task automatic test_servo_window();
		send_line("T2000", CHAR_LF);
		send_line("t999", CHAR_CR);
		settle();
	endtask

	// Empty line, explicit zero, skipped characters and an unknown letter
	// at the extremes of the character range.
	task automatic test_odd_lines();
		send_char(CHAR_LF);
		send_line("S0", CHAR_CR);
		send_line("w7x9", CHAR_LF);
		send_char(8'hFF);
		send_char(8'h00);
		send_char(CHAR_CR);
		settle();
	endtask

	// A line that exactly fills the buffer decodes; one more character
	// overflows it, and the terminator after it finds an empty line.
	task automatic test_overflow();
		send_line("d1234567", CHAR_CR);
		send_line("W12345678", CHAR_LF);
		settle();
	endtask

	// Hold the receiver off for a long stretch while lines keep coming, so
	// the output register fills and the character input backs up.
	task automatic test_backpressure();
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		hold_req <= 1'b1;
		repeat (12) send_random_line();
		settle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int stop_at;
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		stop_at = bytes_sent + PHASE_BYTES;
		while (bytes_sent < stop_at)
			send_random_line();
		settle();
	endtask

	// --------------------------------------------------------------------
	// Sequence
	// --------------------------------------------------------------------
	initial begin
		int unsigned lo;
		// known levels on every input before reset lifts
		arst_n         = 1'b0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.addr    = '0;
		cfg_ch.data    = '0;
		res_ch.ready   = 1'b0;
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		reg_fwd_speed  = RST_FWD_SPEED;
		reg_bwd_speed  = RST_BWD_SPEED;
		reg_turn_speed = RST_TURN_SPEED;
		reg_turn_level = RST_TURN_LEVEL;
		reg_limit      = RST_LIMIT;
		reg_servo_min  = RST_SERVO_MIN;
		reg_servo_max  = RST_SERVO_MAX;
		chars_held     = 0;
		foreach (cmd_tally[k])
			cmd_tally[k] = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset register values
		test_drive_letters();
		test_servo_window();
		test_odd_lines();
		test_overflow();
		test_backpressure();

		// in-range settings with a narrow servo window; no idling
		lo = $urandom_range(60000);
		apply_settings(CFG_DW'($urandom_range(100, 1)), CFG_DW'($urandom_range(100, 1)),
			CFG_DW'($urandom_range(100)), CFG_DW'($urandom_range(100, 1)),
			CFG_DW'($urandom_range(100, 1)), CFG_DW'(lo),
			CFG_DW'(lo + $urandom_range(3000)));
		test_random_traffic(0, 0);

		// everything at its top value, full servo window; sender idles
		apply_settings(16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h0000, 16'hFFFF);
		test_random_traffic(57, 0);

		// everything zero and an inverted servo window; receiver stalls
		apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
		test_random_traffic(0, 57);

		// raw random words, upper bits included; light idling both sides
		apply_settings(CFG_DW'($urandom_range(65535)), CFG_DW'($urandom_range(65535)),
			CFG_DW'($urandom_range(65535)), CFG_DW'($urandom_range(65535)),
			CFG_DW'($urandom_range(65535)), CFG_DW'($urandom_range(65535)),
			CFG_DW'($urandom_range(65535)));
		test_random_traffic(10, 10);

		if (pending_cmds.size() != 0) begin
			$error("%0d predicted results never arrived", pending_cmds.size());
			fail_count++;
		end
		$display("Run covered %0d characters, %0d results checked, %0d register settings.",
			bytes_sent, results_seen, settings_used);
		$display("By code: fwd %0d bwd %0d left %0d right %0d stop %0d servo %0d",
			cmd_tally[CMD_FORWARD], cmd_tally[CMD_BACKWARD], cmd_tally[CMD_LEFT],
			cmd_tally[CMD_RIGHT], cmd_tally[CMD_STOP], cmd_tally[CMD_SERVO],
			" bad angle %0d unknown %0d too long %0d", cmd_tally[CMD_BAD_ANGLE],
			cmd_tally[CMD_UNKNOWN], cmd_tally[CMD_TOO_LONG]);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/scp_pkg.sv
rtl/scp_if.sv
rtl/scp_ctrl.sv
rtl/scp_dp.sv
rtl/serial_drive_command_parser.sv
dv/tb.sv
